/* hw/rtl/dtr_pkg.sv */
// Package with the types, codes and helpers of the divider and timer block.
package dtr_pkg;

   localparam int DivWidth       = 16;
   localparam int TimerWidth     = 8;
   localparam int CtrlWidth      = 3;
   localparam int WaitWidth      = 3;
   localparam int BitIndexWidth  = 4;
   localparam int CsrIndexWidth  = 1;
   localparam int CsrDataWidth   = 1;

   localparam logic [DivWidth-1:0]      DivResetMono = 16'hAB00;
   localparam logic [DivWidth-1:0]      DivResetColor = 16'h0000;
   localparam logic [TimerWidth-1:0]    CtrlHighOnes = 8'b1111_1000;
   localparam logic [CtrlWidth-1:0]     CtrlMask = 3'b111;
   localparam logic [BitIndexWidth-1:0] FrameBit = 4'd12;
   localparam logic [WaitWidth-1:0]     ReloadTicks = 3'd4;

   typedef enum logic [1:0] {
      ActTick  = 2'd0,
      ActRead  = 2'd1,
      ActWrite = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      RegDiv  = 2'd0,
      RegTima = 2'd1,
      RegTma  = 2'd2,
      RegTac  = 2'd3
   } reg_select_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrColorModel  = 1'd0,
      CsrDoubleSpeed = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      PhNormal   = 3'b001,
      PhPending  = 3'b010,
      PhReloaded = 3'b100
   } phase_type;

   // Divider bit that clocks the timer for the given control setting.
   function automatic logic [BitIndexWidth-1:0] tap_index(input logic [1:0] sel,
                                                          input logic dbl);
      logic [BitIndexWidth-1:0] base;
      case (sel)
         2'd0: base = 4'd9;
         2'd1: base = 4'd3;
         2'd2: base = 4'd5;
         2'd3: base = 4'd7;
         default: base = 4'd9;
      endcase
      return base + {3'd0, dbl};
   endfunction

endpackage

/* hw/rtl/dtr_if.sv */
// Channel interfaces for request words, response words and register writes.
interface dtr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] reg_select;
   logic [7:0] write_data;
   logic       tick_hold;
   modport source (output valid, action, reg_select, write_data, tick_hold, input ready);
   modport sink (input valid, action, reg_select, write_data, tick_hold, output ready);
endinterface

interface dtr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       timer_irq;
   logic       frame_tick;
   modport source (output valid, read_data, timer_irq, frame_tick, input ready);
   modport sink (input valid, read_data, timer_irq, frame_tick, output ready);
endinterface

interface dtr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dtr_pkg::CsrIndexWidth-1:0]   index;
   logic [dtr_pkg::CsrDataWidth-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/divider_timer_with_delayed_reload_top.sv */
// Top level of the free-running divider and timer with delayed reload.
//
//   channel  | direction | contents
//   req_ch   | in        | action, reg_select, write_data, tick_hold
//   rsp_ch   | out       | read_data, timer_irq, frame_tick
//   csr_ch   | in        | index, data (color model, double speed)
//
// One word is taken every cycle unless a stalled response holds the input register;
// each word passes the input register, then the response register. Both hold one
// word each, so a stalled response still lets one more word in. Reset is synchronous
// and loads the divider with its monochrome value.
module divider_timer_with_delayed_reload_top (
   input  logic         clock,
   input  logic         reset,
   dtr_req_if.sink      req_ch,
   dtr_rsp_if.source    rsp_ch,
   dtr_csr_if.sink      csr_ch
);

   logic                                 s1_valid_ff, s1_valid_in;
   logic [1:0]                           s1_action_ff;
   logic [1:0]                           s1_sel_ff;
   logic [7:0]                           s1_data_ff;
   logic                                 s1_hold_ff;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]                           rd_ff, rd_in;
   logic                                 irq_ff, irq_in;
   logic                                 frame_ff, frame_in;

   logic                                 dbl_ff;
   logic [dtr_pkg::DivWidth-1:0]         div_ff, div_in;
   logic [dtr_pkg::TimerWidth-1:0]       tc_ff, tc_in;
   logic [dtr_pkg::TimerWidth-1:0]       tm_ff, tm_in;
   logic [dtr_pkg::CtrlWidth-1:0]        ctrl_ff, ctrl_in;
   dtr_pkg::phase_type                   phase_ff, phase_in;
   logic [dtr_pkg::WaitWidth-1:0]        wait_ff, wait_in;

   logic                                 advance;
   logic                                 csr_color_wr;
   logic                                 load_div;
   logic [dtr_pkg::DivWidth-1:0]         load_val;
   logic [dtr_pkg::DivWidth-1:0]         falling;
   logic                                 bump;
   logic [dtr_pkg::TimerWidth-1:0]       bump_sum;
   logic [dtr_pkg::CtrlWidth-1:0]        new_ctrl;
   logic                                 old_high;
   logic                                 new_high;
   logic [dtr_pkg::WaitWidth-1:0]        wait_dec;
   logic [dtr_pkg::BitIndexWidth-1:0]    frame_idx;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign csr_ch.ready = 1'b1;
   assign s1_valid_in  = (req_ch.valid && req_ch.ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign frame_idx    = dtr_pkg::FrameBit + {3'd0, dbl_ff};
   assign csr_color_wr = csr_ch.valid && csr_ch.ready &&
                         (dtr_pkg::csr_index_type'(csr_ch.index) == dtr_pkg::CsrColorModel);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_data  = rd_ff;
   assign rsp_ch.timer_irq  = irq_ff;
   assign rsp_ch.frame_tick = frame_ff;

   always_comb begin
      div_in   = div_ff;
      tc_in    = tc_ff;
      tm_in    = tm_ff;
      ctrl_in  = ctrl_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      rd_in    = '0;
      irq_in   = 1'b0;
      frame_in = 1'b0;
      load_div = 1'b0;
      load_val = '0;
      falling  = '0;
      bump     = 1'b0;
      bump_sum = '0;
      new_ctrl = s1_data_ff[dtr_pkg::CtrlWidth-1:0] & dtr_pkg::CtrlMask;
      old_high = ctrl_ff[2] && div_ff[dtr_pkg::tap_index(ctrl_ff[1:0], dbl_ff)];
      new_high = new_ctrl[2] && div_ff[dtr_pkg::tap_index(new_ctrl[1:0], dbl_ff)];
      wait_dec = wait_ff - 3'd1;
      if (advance) begin
         case (dtr_pkg::action_type'(s1_action_ff))
            dtr_pkg::ActTick: begin
               if (!s1_hold_ff) begin
                  if (phase_ff != dtr_pkg::PhNormal) begin
                     wait_in = wait_dec;
                     if (wait_dec == '0) begin
                        if (phase_ff == dtr_pkg::PhPending) begin
                           tc_in    = tm_ff;
                           phase_in = dtr_pkg::PhReloaded;
                           wait_in  = dtr_pkg::ReloadTicks;
                           irq_in   = 1'b1;
                        end else begin
                           phase_in = dtr_pkg::PhNormal;
                        end
                     end
                  end
                  load_div = 1'b1;
                  load_val = div_ff + 16'd1;
               end
            end
            dtr_pkg::ActRead: begin
               case (dtr_pkg::reg_select_type'(s1_sel_ff))
                  dtr_pkg::RegDiv:  rd_in = div_ff[dtr_pkg::DivWidth-1 -: 8];
                  dtr_pkg::RegTima: rd_in = (phase_ff == dtr_pkg::PhPending) ? 8'd0 : tc_ff;
                  dtr_pkg::RegTma:  rd_in = tm_ff;
                  dtr_pkg::RegTac:  rd_in = dtr_pkg::CtrlHighOnes | {5'd0, ctrl_ff};
                  default:          rd_in = '0;
               endcase
            end
            dtr_pkg::ActWrite: begin
               case (dtr_pkg::reg_select_type'(s1_sel_ff))
                  dtr_pkg::RegDiv: begin
                     load_div = 1'b1;
                     load_val = '0;
                  end
                  dtr_pkg::RegTima: begin
                     if (phase_ff != dtr_pkg::PhReloaded) begin
                        tc_in = s1_data_ff;
                     end
                  end
                  dtr_pkg::RegTma: begin
                     tm_in = s1_data_ff;
                     if (phase_ff != dtr_pkg::PhNormal) begin
                        tc_in = s1_data_ff;
                     end
                  end
                  dtr_pkg::RegTac: begin
                     bump    = old_high && !new_high;
                     ctrl_in = new_ctrl;
                  end
                  default: begin
                     tc_in = tc_ff;
                  end
               endcase
            end
            default: begin
               rd_in = '0;
            end
         endcase
         if (load_div) begin
            falling = div_ff & ~load_val;
            if (ctrl_ff[2] && falling[dtr_pkg::tap_index(ctrl_ff[1:0], dbl_ff)]) begin
               bump = 1'b1;
            end
            div_in   = load_val;
            frame_in = div_ff[frame_idx] && !load_val[frame_idx];
         end
         if (bump) begin
            bump_sum = tc_in + 8'd1;
            if (bump_sum == '0) begin
               tc_in    = tm_in;
               phase_in = dtr_pkg::PhPending;
               wait_in  = dtr_pkg::ReloadTicks;
            end else begin
               tc_in = bump_sum;
            end
         end
      end
      if (csr_color_wr) begin
         div_in = csr_ch.data[0] ? dtr_pkg::DivResetColor : dtr_pkg::DivResetMono;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dbl_ff       <= 1'b0;
         div_ff       <= dtr_pkg::DivResetMono;
         tc_ff        <= '0;
         tm_ff        <= '0;
         ctrl_ff      <= '0;
         phase_ff     <= dtr_pkg::PhNormal;
         wait_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         tc_ff        <= tc_in;
         tm_ff        <= tm_in;
         ctrl_ff      <= ctrl_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (dtr_pkg::csr_index_type'(csr_ch.index))
               dtr_pkg::CsrDoubleSpeed: begin
                  dbl_ff <= csr_ch.data[0];
               end
               default: begin
                  dbl_ff <= dbl_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_action_ff <= req_ch.action;
         s1_sel_ff    <= req_ch.reg_select;
         s1_data_ff   <= req_ch.write_data;
         s1_hold_ff   <= req_ch.tick_hold;
      end
      if (advance) begin
         rd_ff    <= rd_in;
         irq_ff   <= irq_in;
         frame_ff <= frame_in;
      end
   end

   a_wait_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != dtr_pkg::PhNormal |-> wait_ff != '0)
      else $error("reload phase active with an empty wait counter");

   a_word_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("buffered request word dropped without being processed");

   a_irq_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && irq_ff |-> rd_ff == '0)
      else $error("interrupt reported on a register read");

   a_frame_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_ff |-> rd_ff == '0)
      else $error("frame tick reported on a register read");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the divider and timer block with delayed reload.
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] ActUnused = 2'd3;
   localparam int CycleLimit = 500000;
   localparam int HoldOffCycles = 80;
   localparam int WordsPerMode = 170;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
      logic       frame_tick;
   } reply_type;

   logic clock;
   logic reset;

   dtr_req_if req_ch ();
   dtr_rsp_if rsp_ch ();
   dtr_csr_if csr_ch ();

   divider_timer_with_delayed_reload_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted state of the block.
   logic [15:0]        div_count;
   logic [15:0]        div_last;
   logic [7:0]         timer_value;
   logic [7:0]         modulo_byte;
   logic [2:0]         ctrl_value;
   dtr_pkg::phase_type phase;
   logic [2:0]         wait_ticks;
   logic               speed_double;

   reply_type due_replies[$];

   int  words_sent;
   int  replies_checked;
   int  irq_seen;
   int  frame_seen;
   int  overflows;
   int  mismatches;
   int  cycle_count;
   int  stall_left;
   bit  idle_on;
   bit  stalls_on;
   bit  hold_rsp;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d responses pending", cycle_count,
                  due_replies.size());
         $display("divider_timer_with_delayed_reload_top test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic int timer_tap(logic [2:0] ctrl);
      int base;
      case (ctrl[1:0])
         2'd0: base = 9;
         2'd1: base = 3;
         2'd2: base = 5;
         default: base = 7;
      endcase
      return base + int'(speed_double);
   endfunction

   function automatic void bump_timer();
      timer_value = timer_value + 8'd1;
      if (timer_value == 8'd0) begin
         timer_value = modulo_byte;
         phase = dtr_pkg::PhPending;
         wait_ticks = dtr_pkg::ReloadTicks;
         overflows++;
      end
   endfunction

   // Moves the divider to a new value and returns whether the frame bit fell.
   function automatic logic shift_divider(logic [15:0] next);
      int fb;
      logic [15:0] falling;
      fb = int'(dtr_pkg::FrameBit) + int'(speed_double);
      falling = div_count & ~next;
      div_last = div_count;
      if (ctrl_value[2] && falling[timer_tap(ctrl_value)]) bump_timer();
      div_count = next;
      return div_last[fb] && !div_count[fb];
   endfunction

   function automatic reply_type predict_reply(logic [1:0] act, logic [1:0] sel,
                                               logic [7:0] data, logic hold);
      reply_type r;
      logic [2:0] nc;
      logic old_high;
      logic new_high;
      r = '0;
      case (act)
         dtr_pkg::ActTick: begin
            if (!hold) begin
               if (phase != dtr_pkg::PhNormal) begin
                  wait_ticks = wait_ticks - 3'd1;
                  if (wait_ticks == 3'd0) begin
                     if (phase == dtr_pkg::PhPending) begin
                        timer_value = modulo_byte;
                        phase = dtr_pkg::PhReloaded;
                        wait_ticks = dtr_pkg::ReloadTicks;
                        r.timer_irq = 1'b1;
                     end else begin
                        phase = dtr_pkg::PhNormal;
                     end
                  end
               end
               r.frame_tick = shift_divider(div_count + 16'd1);
            end
         end
         dtr_pkg::ActRead: begin
            case (sel)
               dtr_pkg::RegDiv: r.read_data = div_count[15:8];
               dtr_pkg::RegTima:
                  r.read_data = (phase == dtr_pkg::PhPending) ? 8'd0 : timer_value;
               dtr_pkg::RegTma: r.read_data = modulo_byte;
               default: r.read_data = dtr_pkg::CtrlHighOnes | {5'd0, ctrl_value};
            endcase
         end
         dtr_pkg::ActWrite: begin
            case (sel)
               dtr_pkg::RegDiv: r.frame_tick = shift_divider(16'd0);
               dtr_pkg::RegTima: begin
                  if (phase != dtr_pkg::PhReloaded) timer_value = data;
               end
               dtr_pkg::RegTma: begin
                  modulo_byte = data;
                  if (phase != dtr_pkg::PhNormal) timer_value = data;
               end
               default: begin
                  nc = data[2:0] & dtr_pkg::CtrlMask;
                  old_high = ctrl_value[2] && div_count[timer_tap(ctrl_value)];
                  new_high = nc[2] && div_count[timer_tap(nc)];
                  if (old_high && !new_high) bump_timer();
                  ctrl_value = nc;
               end
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch in %s: got 0x%0h, expected 0x%0h (response %0d)",
                  what, got, want, replies_checked);
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = '{rsp_ch.read_data, rsp_ch.timer_irq, rsp_ch.frame_tick};
         if (due_replies.size() == 0) begin
            report_mismatch("unexpected response word", int'(seen), 0);
         end else begin
            want = due_replies.pop_front();
            if (seen.read_data !== want.read_data)
               report_mismatch("read_data", seen.read_data, want.read_data);
            if (seen.timer_irq !== want.timer_irq)
               report_mismatch("timer_irq", seen.timer_irq, want.timer_irq);
            if (seen.frame_tick !== want.frame_tick)
               report_mismatch("frame_tick", seen.frame_tick, want.frame_tick);
            if (want.timer_irq) irq_seen++;
            if (want.frame_tick) frame_seen++;
            replies_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ch.ready = 1'b0;
      end else if (stall_left != 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (stalls_on && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
   end

   // Called at a falling edge; returns at a falling edge with the word accepted.
   task automatic send_word(logic [1:0] act, logic [1:0] sel, logic [7:0] data,
                            logic hold);
      int gap;
      req_ch.action = act;
      req_ch.reg_select = sel;
      req_ch.write_data = data;
      req_ch.tick_hold = hold;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      due_replies.push_back(predict_reply(act, sel, data, hold));
      words_sent++;
      @(negedge clock);
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 25) gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      req_ch.valid = 1'b0;
      while (due_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(dtr_pkg::csr_index_type idx, logic val);
      drain_replies();
      csr_ch.index = idx;
      csr_ch.data = val;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (idx == dtr_pkg::CsrColorModel) begin
         div_count = val ? dtr_pkg::DivResetColor : dtr_pkg::DivResetMono;
         div_last = div_count;
      end else begin
         speed_double = val;
      end
      @(negedge clock);
      csr_ch.valid = 1'b0;
      repeat (2) @(negedge clock);
   endtask

   task automatic send_tick();
      send_word(dtr_pkg::ActTick, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'b0);
   endtask

   task automatic test_register_access();
      send_word(dtr_pkg::ActRead, dtr_pkg::RegDiv, 8'h00, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'h00, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTma, 8'h00, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTac, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTac, 8'hFF, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTac, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTma, 8'hFF, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTma, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTma, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTima, 8'hFF, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegDiv, 8'h5A, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegDiv, 8'h00, 1'b0);
      send_word(dtr_pkg::ActTick, dtr_pkg::RegTac, 8'hFF, 1'b1);
      send_word(ActUnused, dtr_pkg::RegTac, 8'hFF, 1'b1);
   endtask

   // A control write that drops a high tap overflows the counter; the reload
   // window then covers a modulo write while pending and an ignored timer write.
   task automatic test_overflow_reload();
      repeat (8) send_tick();
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTac, 8'h05, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTac, 8'h01, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'h00, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTma, 8'h3C, 1'b0);
      repeat (4) send_tick();
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTima, 8'h55, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'h00, 1'b0);
      repeat (4) send_tick();
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTima, 8'h77, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'h00, 1'b0);
   endtask

   task automatic test_frame_edge();
      write_mode(dtr_pkg::CsrDoubleSpeed, 1'b1);
      write_mode(dtr_pkg::CsrColorModel, 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegDiv, 8'h00, 1'b0);
      write_mode(dtr_pkg::CsrColorModel, 1'b1);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegDiv, 8'h00, 1'b0);
      write_mode(dtr_pkg::CsrDoubleSpeed, 1'b0);
      write_mode(dtr_pkg::CsrColorModel, 1'b0);
      send_word(dtr_pkg::ActRead, dtr_pkg::RegDiv, 8'h00, 1'b0);
   endtask

   task automatic run_overflow_sequence();
      int n;
      int r;
      logic [7:0] ctrl;
      ctrl = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) ctrl[2:0] = 3'b101;
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTma, 8'($urandom_range(0, 255)), 1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTima, 8'($urandom_range(8'hFB, 8'hFF)),
                1'b0);
      send_word(dtr_pkg::ActWrite, dtr_pkg::RegTac, ctrl, 1'b0);
      n = $urandom_range(30, 90);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 68)
            send_word(dtr_pkg::ActTick, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         else if (r < 80)
            send_word(dtr_pkg::ActRead, dtr_pkg::RegTima, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         else if (r < 85)
            send_word(dtr_pkg::ActRead, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), 1'b0);
         else if (r < 90)
            send_word(dtr_pkg::ActWrite, dtr_pkg::RegTima, 8'($urandom_range(0, 255)),
                      1'b0);
         else if (r < 94)
            send_word(dtr_pkg::ActWrite, dtr_pkg::RegTma, 8'($urandom_range(0, 255)),
                      1'b0);
         else if (r < 97)
            send_word(dtr_pkg::ActWrite, dtr_pkg::RegDiv, 8'($urandom_range(0, 255)),
                      1'b0);
         else
            send_word(dtr_pkg::ActWrite, dtr_pkg::RegTac, 8'($urandom_range(0, 255)),
                      1'b0);
      end
   endtask

   task automatic run_noise_burst();
      int r;
      logic [1:0] act;
      repeat ($urandom_range(10, 25)) begin
         r = $urandom_range(0, 19);
         if (r == 0) act = ActUnused;
         else if (r < 8) act = dtr_pkg::ActTick;
         else if (r < 13) act = dtr_pkg::ActRead;
         else act = dtr_pkg::ActWrite;
         send_word(act, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_tick_stretch();
      repeat ($urandom_range(100, 300))
         send_word(dtr_pkg::ActTick, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 29) == 0);
   endtask

   task automatic test_random_traffic();
      int start;
      int r;
      for (int m = 3; m >= 0; m--) begin
         write_mode(dtr_pkg::CsrColorModel, m[1]);
         write_mode(dtr_pkg::CsrDoubleSpeed, m[0]);
         start = words_sent;
         while (words_sent - start < WordsPerMode) begin
            idle_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 99);
            if (r < 75) run_overflow_sequence();
            else if (r < 90) run_noise_burst();
            else run_tick_stretch();
         end
      end
   endtask

   task automatic test_output_backpressure();
      drain_replies();
      idle_on = 1'b0;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
            hold_rsp = 1'b0;
         end
         repeat (30) begin
            send_tick();
            send_word(dtr_pkg::ActRead, dtr_pkg::RegDiv, 8'h00, 1'b0);
         end
      join
      idle_on = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = dtr_pkg::ActTick;
      req_ch.reg_select = dtr_pkg::RegDiv;
      req_ch.write_data = 8'h00;
      req_ch.tick_hold = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = dtr_pkg::CsrColorModel;
      csr_ch.data = 1'b0;
      div_count = dtr_pkg::DivResetMono;
      div_last = dtr_pkg::DivResetMono;
      timer_value = 8'h00;
      modulo_byte = 8'h00;
      ctrl_value = 3'd0;
      phase = dtr_pkg::PhNormal;
      wait_ticks = 3'd0;
      speed_double = 1'b0;
      idle_on = 1'b1;
      stalls_on = 1'b1;
      hold_rsp = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      test_register_access();
      test_overflow_reload();
      test_frame_edge();
      test_random_traffic();
      test_output_backpressure();

      drain_replies();
      repeat (10) @(posedge clock);
      $display("Sent %0d request words and checked %0d responses in %0d cycles.",
               words_sent, replies_checked, cycle_count);
      $display("Saw %0d counter overflows, %0d timer interrupts and %0d frame edges.",
               overflows, irq_seen, frame_seen);
      if (mismatches == 0) begin
         $display("divider_timer_with_delayed_reload_top test passed");
      end else begin
         $display("divider_timer_with_delayed_reload_top test failed");
      end
      $finish;
   end

endmodule
